// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the escape-time pixel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the standard clk_i and rst_ni of a module.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: hw/rtl/mep_pkg.sv
// Shared types, constants and helper functions of the escape-time pixel block.
`default_nettype none

package mep_pkg;

  // Default parameter values.
  localparam int CoordBitsDef = 10;
  localparam int FracBitsDef  = 28;

  // Fixed widths.
  localparam int CountBits = 12;
  localparam int ZBits     = 32;
  localparam int StepBits  = 31;
  localparam int QBits     = 16;
  localparam int AddrBits  = 5;
  localparam int DataBits  = 32;
  localparam int DivSteps  = QBits;

  // Register reset values.
  localparam logic signed [ZBits-1:0] RealOriginRst = -32'sd536870912;
  localparam logic [StepBits-1:0]     RealStepRst   = 31'd1258291;
  localparam logic signed [ZBits-1:0] ImagOriginRst = 32'sd402653184;
  localparam logic [StepBits-1:0]     ImagStepRst   = 31'd1677722;
  localparam logic [CountBits-1:0]    LimitRst      = 12'd1000;

  // Color scale factors (9*255, 15*255, 8.5*255*2).
  localparam logic [11:0] RedScale   = 12'd2295;
  localparam logic [11:0] GreenScale = 12'd3825;
  localparam logic [12:0] BlueScale  = 13'd4335;

  // Register index in the address map.
  typedef enum logic [2:0] {
    REG_REAL_ORIGIN = 3'd0,
    REG_REAL_STEP   = 3'd1,
    REG_IMAG_ORIGIN = 3'd2,
    REG_IMAG_STEP   = 3'd3,
    REG_LIMIT       = 3'd4
  } mep_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_COLOR,
    ST_DONE
  } mep_state_e;

  // Steps of the color polynomial sequence, one multiply each.
  typedef enum logic [3:0] {
    CS_TT,
    CS_AT,
    CS_PU1,
    CS_RED,
    CS_AU,
    CS_PU2,
    CS_GREEN,
    CS_TU,
    CS_PU3,
    CS_PU4,
    CS_BLUE
  } mep_cstep_e;

  // Configuration register set.
  typedef struct packed {
    logic signed [ZBits-1:0] real_origin;
    logic [StepBits-1:0]     real_step;
    logic signed [ZBits-1:0] imag_origin;
    logic [StepBits-1:0]     imag_step;
    logic [CountBits-1:0]    limit;
  } mep_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       coord;
    logic       mul;
    logic       add;
    logic       div_step;
    logic       col_step;
    mep_cstep_e cstep;
    logic       load_out;
  } mep_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic esc;
    logic at_limit;
  } mep_sts_t;

  // Saturate a 64-bit signed value to the 32-bit signed range.
  function automatic logic signed [ZBits-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[ZBits-1:0];
    end
  endfunction

  // Clamp an unsigned value to one color channel.
  function automatic logic [7:0] sat8(input logic [17:0] v);
    sat8 = (v > 18'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mep_ctrl.sv
// Controller state machine that sequences coordinate, iteration, divide and color steps.
`default_nettype none

module mep_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mep_pkg::mep_sts_t sts_i,
  output mep_pkg::mep_cmd_t      cmd_o
);
  import mep_pkg::*;

  mep_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       div_last;
  logic       col_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign div_last = (cnt_q == 4'(DivSteps - 1));
  assign col_last = (cnt_q == 4'(CS_BLUE));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_COORD;
      ST_COORD: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD: begin
        if (sts_i.esc) begin
          state_d = ST_DIV;
        end else if (sts_i.at_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DIV:   if (div_last) state_d = ST_COLOR;
      ST_COLOR: if (col_last) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Step counter for the divide and color sequences.
  always_comb begin
    cnt_d = '0;
    if (state_q == ST_DIV) begin
      cnt_d = div_last ? '0 : cnt_q + 4'd1;
    end else if (state_q == ST_COLOR) begin
      cnt_d = col_last ? '0 : cnt_q + 4'd1;
    end
  end

  // Command outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.cstep    = mep_cstep_e'(cnt_q);
    cmd_o.load_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.coord    = (state_q == ST_COORD);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.add      = (state_q == ST_ADD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.col_step = (state_q == ST_COLOR);
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
  end

  // Output valid flag: set when a result is loaded, cleared on transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `include "assert_macros.svh"

  // A finished pixel always lands in the output register and frees the block.
  `ASSERT_STD(a_done_to_idle, (state_q == ST_DONE) && out_free |=> (state_q == ST_IDLE) && out_valid_q, "result not loaded on leaving done")
  // The output valid flag only rises from the done state.
  `ASSERT_STD(a_valid_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "output valid rose outside done")
  // The step counter stays clear outside the divide and color sequences.
  `ASSERT_STD(a_cnt_clear, (state_q != ST_DIV) && (state_q != ST_COLOR) |=> (cnt_q == '0) || (state_q == ST_DIV) || (state_q == ST_COLOR), "step counter left running")

endmodule

`default_nettype wire

// File: hw/rtl/mep_dpath.sv
// Datapath: point mapping, orbit iteration, escape test, divider and color multiplier.
`default_nettype none

module mep_dpath #(
  parameter int CoordBits = mep_pkg::CoordBitsDef,
  parameter int FracBits  = mep_pkg::FracBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mep_pkg::mep_cmd_t              cmd_i,
  output mep_pkg::mep_sts_t                   sts_o,
  input  wire mep_pkg::mep_cfg_t              cfg_i,
  input  wire logic [CoordBits-1:0]           pixel_x_i,
  input  wire logic [CoordBits-1:0]           pixel_y_i,
  output logic [mep_pkg::CountBits-1:0]       iteration_count_o,
  output logic                                escaped_o,
  output logic [7:0]                          red_o,
  output logic [7:0]                          green_o,
  output logic [7:0]                          blue_o
);
  import mep_pkg::*;

  localparam int PBits = CoordBits + StepBits;
  localparam int TShift = 2 * FracBits + 2;
  localparam bit CanEsc = (TShift < 64);
  localparam logic [63:0] Thresh = CanEsc ? (64'd1 << TShift) : 64'd0;

  logic [CoordBits-1:0]    px_q, py_q;
  logic signed [ZBits-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [63:0]      rr_q, ii_q, ri_q;
  logic [CountBits-1:0]    k_q;

  logic [PBits-1:0]        rprod, iprod;
  logic signed [63:0]      cre, cie;
  logic signed [63:0]      diff, nr_w, ni_w;
  logic [63:0]             mag2;
  logic signed [ZBits-1:0] nr, ni;

  // Point mapping: real = origin + x * step, imag = origin - y * step, saturated.
  assign rprod = PBits'(px_q) * PBits'(cfg_i.real_step);
  assign iprod = PBits'(py_q) * PBits'(cfg_i.imag_step);
  assign cre   = 64'(cfg_i.real_origin) + 64'(rprod);
  assign cie   = 64'(cfg_i.imag_origin) - 64'(iprod);

  // Orbit update from the registered products.
  assign diff = rr_q - ii_q;
  assign nr_w = (diff >>> FracBits) + 64'(cr_q);
  assign ni_w = (ri_q >>> (FracBits - 1)) + 64'(ci_q);
  assign nr   = sat32(nr_w);
  assign ni   = sat32(ni_w);

  // Escape test on the squares of the current orbit point.
  assign mag2           = rr_q + ii_q;
  assign sts_o.esc      = (k_q != '0) && CanEsc && (mag2 > Thresh);
  assign sts_o.at_limit = (k_q == cfg_i.limit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (cmd_i.coord) begin
      cr_q <= sat32(cre);
      ci_q <= sat32(cie);
      zr_q <= '0;
      zi_q <= '0;
      k_q  <= '0;
    end
    if (cmd_i.mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (cmd_i.add && !sts_o.esc && !sts_o.at_limit) begin
      zr_q <= nr;
      zi_q <= ni;
      k_q  <= k_q + 1'b1;
    end
  end

  // Restoring divider for t = count * 2^16 / limit, one quotient bit per cycle.
  logic [CountBits-1:0] rem_q;
  logic [QBits-1:0]     t_q;
  logic [CountBits:0]   rem2;
  logic                 ge;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = (rem2 >= {1'b0, cfg_i.limit});

  // Working result registers.
  logic [CountBits-1:0] cnt_w_q;
  logic                 esc_w_q;
  logic [7:0]           red_w_q, green_w_q, blue_w_q;
  logic [QBits:0]       a_q, p_q;

  // Shared color multiplier with operand selection per step.
  logic [QBits:0]       u;
  logic [QBits:0]       opa, opb;
  logic [2*QBits+1:0]   prod;

  assign u    = (QBits + 1)'(1 << QBits) - {1'b0, t_q};
  assign prod = opa * opb;

  always_comb begin
    opa = {1'b0, t_q};
    opb = {1'b0, t_q};
    case (cmd_i.cstep)
      CS_TT: begin
        opa = {1'b0, t_q};
        opb = {1'b0, t_q};
      end
      CS_AT: begin
        opa = a_q;
        opb = {1'b0, t_q};
      end
      CS_PU1, CS_PU2, CS_PU3, CS_PU4: begin
        opa = p_q;
        opb = u;
      end
      CS_RED: begin
        opa = p_q;
        opb = (QBits + 1)'(RedScale);
      end
      CS_AU: begin
        opa = a_q;
        opb = u;
      end
      CS_GREEN: begin
        opa = p_q;
        opb = (QBits + 1)'(GreenScale);
      end
      CS_TU: begin
        opa = {1'b0, t_q};
        opb = u;
      end
      CS_BLUE: begin
        opa = p_q;
        opb = (QBits + 1)'(BlueScale);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      if (sts_o.esc) begin
        cnt_w_q <= k_q - 1'b1;
        esc_w_q <= 1'b1;
        rem_q   <= k_q - 1'b1;
        t_q     <= '0;
      end else if (sts_o.at_limit) begin
        cnt_w_q   <= '0;
        esc_w_q   <= 1'b0;
        red_w_q   <= '0;
        green_w_q <= '0;
        blue_w_q  <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? CountBits'(rem2 - {1'b0, cfg_i.limit}) : rem2[CountBits-1:0];
      t_q   <= {t_q[QBits-2:0], ge};
    end
    if (cmd_i.col_step) begin
      case (cmd_i.cstep)
        CS_TT: begin
          p_q <= prod[2*QBits:QBits];
          a_q <= prod[2*QBits:QBits];
        end
        CS_RED:   red_w_q   <= sat8(prod[2*QBits+1:QBits]);
        CS_GREEN: green_w_q <= sat8(prod[2*QBits+1:QBits]);
        CS_BLUE:  blue_w_q  <= sat8({1'b0, prod[2*QBits+1:QBits+1]});
        default:  p_q <= prod[2*QBits:QBits];
      endcase
    end
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iteration_count_o <= '0;
      escaped_o         <= 1'b0;
      red_o             <= '0;
      green_o           <= '0;
      blue_o            <= '0;
    end else if (cmd_i.load_out) begin
      iteration_count_o <= cnt_w_q;
      escaped_o         <= esc_w_q;
      red_o             <= red_w_q;
      green_o           <= green_w_q;
      blue_o            <= blue_w_q;
    end
  end

  `include "assert_macros.svh"

  // A pixel that did not escape is always reported black with a zero count.
  `ASSERT_STD(a_inside_black, !escaped_o |-> (red_o == '0) && (green_o == '0) && (blue_o == '0) && (iteration_count_o == '0), "inside pixel not black")

endmodule

`default_nettype wire

// File: hw/rtl/mandelbrot_escape_pixel.sv
// A pixel is mapped, then iterated until it escapes or reaches the limit; an escaping pixel
// then runs the divider and 11 color multiplies, while an inside pixel finishes at the limit.
// Each complex step forms the three products in ST_MUL, then the update in ST_ADD.
// One pixel is in work at a time; the next is accepted while a result waits.
// Reset is asynchronous and active low; control, configuration and output registers return to their defaults.
`default_nettype none

module mandelbrot_escape_pixel #(
  parameter int CoordBits = mep_pkg::CoordBitsDef,
  parameter int FracBits  = mep_pkg::FracBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mep_pkg::AddrBits-1:0]   paddr,
  input  wire logic [mep_pkg::DataBits-1:0]   pwdata,
  output logic [mep_pkg::DataBits-1:0]        prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [CoordBits-1:0]           pixel_x_i,
  input  wire logic [CoordBits-1:0]           pixel_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mep_pkg::CountBits-1:0]       iteration_count_o,
  output logic                                escaped_o,
  output logic [7:0]                          red_o,
  output logic [7:0]                          green_o,
  output logic [7:0]                          blue_o
);
  import mep_pkg::*;

  mep_cfg_t cfg_q;
  mep_cmd_t cmd;
  mep_sts_t sts;
  logic     wr_en;

  // Configuration register writes on the access phase of a transfer.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_origin <= RealOriginRst;
      cfg_q.real_step   <= RealStepRst;
      cfg_q.imag_origin <= ImagOriginRst;
      cfg_q.imag_step   <= ImagStepRst;
      cfg_q.limit       <= LimitRst;
    end else if (wr_en) begin
      case (paddr[AddrBits-1:2])
        REG_REAL_ORIGIN: cfg_q.real_origin <= pwdata;
        REG_REAL_STEP:   cfg_q.real_step   <= pwdata[StepBits-1:0];
        REG_IMAG_ORIGIN: cfg_q.imag_origin <= pwdata;
        REG_IMAG_STEP:   cfg_q.imag_step   <= pwdata[StepBits-1:0];
        REG_LIMIT:       cfg_q.limit       <= pwdata[CountBits-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[AddrBits-1:2])
      REG_REAL_ORIGIN: prdata = cfg_q.real_origin;
      REG_REAL_STEP:   prdata = DataBits'(cfg_q.real_step);
      REG_IMAG_ORIGIN: prdata = cfg_q.imag_origin;
      REG_IMAG_STEP:   prdata = DataBits'(cfg_q.imag_step);
      REG_LIMIT:       prdata = DataBits'(cfg_q.limit);
      default:         prdata = '0;
    endcase
  end

  mep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mep_dpath #(
    .CoordBits (CoordBits),
    .FracBits  (FracBits)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_i             (cfg_q),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .iteration_count_o (iteration_count_o),
    .escaped_o         (escaped_o),
    .red_o             (red_o),
    .green_o           (green_o),
    .blue_o            (blue_o)
  );

endmodule

`default_nettype wire
